### hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// invariant checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`endif

### hdl/tkqa_pkg.sv
`timescale 1ns / 1ps

package tkqa_pkg;

    // key codes, dense numbering
    typedef enum logic [4:0] {
        KEY_NONE      = 5'd0,
        KEY_FLEXR     = 5'd1,
        KEY_TIMER     = 5'd2,
        KEY_BOOST     = 5'd3,
        KEY_FLEXL     = 5'd4,
        KEY_PAUSE     = 5'd5,
        KEY_LF        = 5'd6,
        KEY_AUTOPOT   = 5'd7,
        KEY_LOCK      = 5'd8,
        KEY_LR        = 5'd9,
        KEY_POWER     = 5'd10,
        KEY_POWERLONG = 5'd11,
        KEY_RR        = 5'd12,
        KEY_RF        = 5'd13,
        KEY_LEVEL0    = 5'd14,
        KEY_LEVEL1    = 5'd15,
        KEY_LEVEL2    = 5'd16,
        KEY_LEVEL3    = 5'd17,
        KEY_LEVEL4    = 5'd18,
        KEY_LEVEL5    = 5'd19,
        KEY_LEVEL6    = 5'd20,
        KEY_LEVEL7    = 5'd21,
        KEY_LEVEL8    = 5'd22,
        KEY_LEVEL9    = 5'd23,
        KEY_TPLUS     = 5'd24,
        KEY_TMINUS    = 5'd25
    } t_key;

    typedef enum logic {
        OP_POLL   = 1'b0,
        OP_ACTION = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRESS = 2'd0,
        CFG_LONG  = 2'd1
    } t_cfg_idx;

    localparam logic [7:0] PRESS_RESET = 8'd5;
    localparam logic [7:0] LONG_RESET  = 8'd50;

    // mode flag bit positions
    localparam int FLAG_LOCK    = 0;
    localparam int FLAG_AUTOPOT = 1;
    localparam int FLAG_PAUSE   = 2;
    localparam int FLAG_BOOST   = 3;
    localparam int FLAG_FLEXL   = 4;
    localparam int FLAG_FLEXR   = 5;

    typedef struct packed {
        t_op         opcode;
        logic        device_is_primary;
        logic [7:0]  touch_low;
        logic [7:0]  touch_high;
    } t_item;

    // chip 0 is the secondary chip, chip 1 the primary; low byte at 2i
    typedef struct packed {
        logic [3:0][7:0] last_pair;
        logic [1:0][7:0] stable_count;
        t_key            key;
        logic            busy;
        logic [5:0]      flags;
        logic [3:0]      select;
        logic [3:0][3:0] levels;
    } t_state;

    function automatic logic is_onehot8(input logic [7:0] b);
        return (b != 8'd0) && ((b & (b - 8'd1)) == 8'd0);
    endfunction

    function automatic logic [2:0] onehot_pos(input logic [7:0] b);
        logic [2:0] p;
        p = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

    function automatic t_key prim_low_key(input logic [2:0] p);
        t_key k;
        case (p)
            3'd0:    k = KEY_FLEXR;
            3'd1:    k = KEY_TIMER;
            3'd2:    k = KEY_BOOST;
            3'd3:    k = KEY_FLEXL;
            3'd4:    k = KEY_PAUSE;
            3'd5:    k = KEY_LF;
            3'd6:    k = KEY_AUTOPOT;
            default: k = KEY_LOCK;
        endcase
        return k;
    endfunction

    function automatic t_key sec_low_key(input logic [2:0] p);
        t_key k;
        case (p)
            3'd0:    k = KEY_LEVEL9;
            3'd1:    k = KEY_LEVEL8;
            3'd2:    k = KEY_LEVEL7;
            3'd3:    k = KEY_LEVEL6;
            3'd4:    k = KEY_LEVEL5;
            3'd5:    k = KEY_LEVEL4;
            3'd6:    k = KEY_LEVEL3;
            default: k = KEY_LEVEL2;
        endcase
        return k;
    endfunction

    function automatic t_key prim_high_key(input logic [1:0] p);
        t_key k;
        case (p)
            2'd0:    k = KEY_LR;
            2'd1:    k = KEY_POWER;
            2'd2:    k = KEY_RR;
            default: k = KEY_RF;
        endcase
        return k;
    endfunction

    function automatic t_key sec_high_key(input logic [1:0] p);
        t_key k;
        case (p)
            2'd0:    k = KEY_LEVEL1;
            2'd1:    k = KEY_LEVEL0;
            2'd2:    k = KEY_TPLUS;
            default: k = KEY_TMINUS;
        endcase
        return k;
    endfunction

    // decode a stable pair into a key, keep the old key when nothing matches
    function automatic t_key decode_key(input logic primary, input logic [7:0] lo,
                                        input logic [7:0] hi, input logic is_long,
                                        input t_key key);
        logic [2:0] p;
        t_key       k;
        k = key;
        p = 3'd0;
        if (hi == 8'd0 && is_onehot8(lo)) begin
            p = onehot_pos(lo);
            k = primary ? prim_low_key(p) : sec_low_key(p);
        end
        if (lo == 8'd0 && is_onehot8(hi) && hi[7:4] == 4'd0) begin
            p = onehot_pos(hi);
            k = primary ? prim_high_key(p[1:0]) : sec_high_key(p[1:0]);
            if (primary && k == KEY_POWER && is_long) begin
                k = KEY_POWERLONG;
            end
        end
        return k;
    endfunction

endpackage

### hdl/tkqa_step.sv
`timescale 1ns / 1ps

module tkqa_step import tkqa_pkg::*; (
    input  t_state     i_state,
    input  t_item      i_item,
    input  logic [7:0] i_press_threshold,
    input  logic [7:0] i_long_threshold,
    output t_state     o_state
);

    logic       w_idx;
    logic [7:0] w_lo;
    logic [7:0] w_hi;
    logic       w_same;
    logic [7:0] w_cnt;
    logic       w_is_long;
    logic       w_reach;
    logic [1:0] w_burner;
    logic [4:0] w_level;

    always_comb begin
        o_state   = i_state;
        w_idx     = i_item.device_is_primary;
        w_lo      = i_item.touch_low;
        w_hi      = i_item.touch_high;
        w_same    = (i_state.last_pair[{w_idx, 1'b0}] == w_lo) &&
                    (i_state.last_pair[{w_idx, 1'b1}] == w_hi);
        w_cnt     = i_state.stable_count[w_idx] + 8'd1;
        w_is_long = (w_cnt >= i_long_threshold);
        w_reach   = w_is_long || (w_cnt >= i_press_threshold);
        w_level   = 5'(i_state.key) - 5'(KEY_LEVEL0);
        // lowest selected burner wins, RF when only it is left
        w_burner  = i_state.select[0] ? 2'd0 :
                    i_state.select[1] ? 2'd1 :
                    i_state.select[2] ? 2'd2 : 2'd3;

        if (i_item.opcode == OP_POLL) begin
            // poll: stability count and key qualification
            if (w_lo == 8'd0 && w_hi == 8'd0) begin
                if (i_state.last_pair == '0) begin
                    o_state.key = KEY_NONE;
                end
                if (w_same) begin
                    o_state.stable_count[w_idx] = 8'd0;
                end
            end else if (w_same) begin
                o_state.stable_count[w_idx] = w_cnt;
                // a pair with both bytes set never decodes
                if ((w_lo == 8'd0 || w_hi == 8'd0) && w_reach) begin
                    o_state.key = decode_key(w_idx, w_lo, w_hi, w_is_long, i_state.key);
                end
            end
            o_state.last_pair[{w_idx, 1'b0}] = w_lo;
            o_state.last_pair[{w_idx, 1'b1}] = w_hi;
            if (o_state.key == KEY_NONE) begin
                o_state.busy = 1'b0;
            end
        end else if (!i_state.busy) begin
            // action on the held key
            unique case (i_state.key) inside
                KEY_LOCK: begin
                    o_state.flags[FLAG_LOCK] = ~i_state.flags[FLAG_LOCK];
                    o_state.busy = 1'b1;
                end
                KEY_AUTOPOT: begin
                    o_state.flags[FLAG_AUTOPOT] = ~i_state.flags[FLAG_AUTOPOT];
                    o_state.busy = 1'b1;
                end
                KEY_PAUSE: begin
                    o_state.flags[FLAG_PAUSE] = ~i_state.flags[FLAG_PAUSE];
                    o_state.busy = 1'b1;
                end
                KEY_BOOST: begin
                    o_state.flags[FLAG_BOOST] = ~i_state.flags[FLAG_BOOST];
                    o_state.busy = 1'b1;
                end
                KEY_TIMER: begin
                    o_state.busy = 1'b1;
                end
                KEY_FLEXL: begin
                    o_state.flags[FLAG_FLEXL] = ~i_state.flags[FLAG_FLEXL];
                    o_state.busy = 1'b1;
                end
                KEY_FLEXR: begin
                    o_state.flags[FLAG_FLEXR] = ~i_state.flags[FLAG_FLEXR];
                    o_state.busy = 1'b1;
                end
                KEY_LR: begin
                    o_state.select = 4'b0001;
                    o_state.busy   = 1'b1;
                end
                KEY_LF: begin
                    o_state.select = 4'b0010;
                    o_state.busy   = 1'b1;
                end
                KEY_RR: begin
                    o_state.select = 4'b0100;
                    o_state.busy   = 1'b1;
                end
                KEY_RF: begin
                    o_state.select = 4'b1000;
                    o_state.busy   = 1'b1;
                end
                [KEY_LEVEL0:KEY_LEVEL9]: begin
                    // level goes to one selected burner, which then drops out
                    if (i_state.select != 4'd0) begin
                        o_state.levels[w_burner] = w_level[3:0];
                        o_state.select[w_burner] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### hdl/touch_key_qualifier_and_action.sv
// an accepted item waits in the input register, and its result is then registered in the
// state/result register, which drives the result ports
// throughput: one item per cycle while i_out_ready does not stall the result register;
// the state update is a single combinational pass between the input register and the state/result register
// reset (synchronous, active low): key none, flags, selection, levels, stored pairs
// and counters cleared, thresholds back to 5 and 50
`timescale 1ns / 1ps
`include "assert_macros.svh"

module touch_key_qualifier_and_action import tkqa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic        i_device_is_primary,
    input  logic [7:0]  i_touch_low,
    input  logic [7:0]  i_touch_high,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_key_code,
    output logic        o_key_busy,
    output logic        o_lock_on,
    output logic        o_auto_pot_on,
    output logic        o_pause_on,
    output logic        o_boost_on,
    output logic        o_flex_left_on,
    output logic        o_flex_right_on,
    output logic [3:0]  o_burner_select,
    output logic [15:0] o_power_levels
);

    logic       r_in_valid;
    t_item      r_item;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic [7:0] r_press;
    logic [7:0] r_long;
    logic       w_adv;
    logic       w_levels_ok;

    // configuration writes are taken at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press <= PRESS_RESET;
            r_long  <= LONG_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PRESS: r_press <= i_cfg_data;
                CFG_LONG:  r_long  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the held item moves on when the result slot is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{opcode: t_op'(i_opcode), device_is_primary: i_device_is_primary,
                        touch_low: i_touch_low, touch_high: i_touch_high};
        end
    end

    tkqa_step u_step (
        .i_state           (r_state),
        .i_item            (r_item),
        .i_press_threshold (r_press),
        .i_long_threshold  (r_long),
        .o_state           (n_state)
    );

    // state register doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result fields
    assign o_out_valid     = r_out_valid;
    assign o_key_code      = 5'(r_state.key);
    assign o_key_busy      = r_state.busy;
    assign o_lock_on       = r_state.flags[FLAG_LOCK];
    assign o_auto_pot_on   = r_state.flags[FLAG_AUTOPOT];
    assign o_pause_on      = r_state.flags[FLAG_PAUSE];
    assign o_boost_on      = r_state.flags[FLAG_BOOST];
    assign o_flex_left_on  = r_state.flags[FLAG_FLEXL];
    assign o_flex_right_on = r_state.flags[FLAG_FLEXR];
    assign o_burner_select = r_state.select;
    assign o_power_levels  = r_state.levels;

    // every stored level stays within 0..9
    assign w_levels_ok = (r_state.levels[0] <= 4'd9) && (r_state.levels[1] <= 4'd9) &&
                         (r_state.levels[2] <= 4'd9) && (r_state.levels[3] <= 4'd9);

    // checks
    `ASSERT_ALWAYS(a_busy_needs_key, !r_state.busy || r_state.key != KEY_NONE, "busy without key")
    `ASSERT_ALWAYS(a_select_onehot0, $onehot0(r_state.select), "more than one burner selected")
    `ASSERT_CLK(a_state_holds, !w_adv |=> $stable(r_state), "state changed without a transfer")
    `ASSERT_ALWAYS(a_levels_range, w_levels_ok, "power level above nine")

endmodule
